// File: src/assert_macros.svh
// Assertion macros shared by the slot pool allocator RTL.
// Every module that asserts has clk and rst_n, which the macros reference.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define ASSERT_CLKED(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication: when cond holds, res holds at the next edge.
`define ASSERT_NEXT(lbl, cond, res, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (res)) else $error(msg);

`endif

// File: src/spia_pkg.sv
// Shared types and constants of the slot pool index allocator.
// No dependencies; every other source file but assert_macros.svh imports this package.
package spia_pkg;

  localparam int IDX_W     = 6;
  localparam int CNT_OUT_W = 7;
  localparam int CAP_W     = 7;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_IGNORED = 2'd2
  } status_t;

  // Outcome of one operation, known in the cycle it is accepted.
  typedef struct packed {
    logic                 alloc_ok;
    status_t              status;
    logic [CNT_OUT_W-1:0] used_count;
  } res_info_t;

endpackage

// File: src/spia_req_if.sv
// Request channel of the slot pool index allocator: valid/ready plus payload.
// Depends on spia_pkg.
interface spia_req_if import spia_pkg::*;;
  logic             valid;
  logic             ready;
  op_t              op;
  logic [IDX_W-1:0] free_index;

  modport source (output valid, output op, output free_index, input ready);
  modport sink (input valid, input op, input free_index, output ready);
endinterface

// File: src/spia_res_if.sv
// Result channel of the slot pool index allocator: valid/ready plus payload.
// Depends on spia_pkg.
interface spia_res_if import spia_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [IDX_W-1:0]     slot_index;
  status_t              status;
  logic [CNT_OUT_W-1:0] used_count;

  modport source (output valid, output slot_index, output status, output used_count,
                  input ready);
  modport sink (input valid, input slot_index, input status, input used_count,
                output ready);
endinterface

// File: src/spia_stack.sv
// Free index stack: single-port synchronous memory with a registered read.
// Depends on spia_pkg and assert_macros.svh.
`include "assert_macros.svh"

module spia_stack import spia_pkg::*; #(
  parameter int SLOTS = 64,
  localparam int AW    = $clog2(SLOTS),
  localparam int CNT_W = $clog2(SLOTS + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fill,
  input  logic             rd_en,
  input  logic             wr_en,
  input  logic [AW-1:0]    addr,
  input  logic [IDX_W-1:0] wdata,
  output logic [IDX_W-1:0] rd_data
);

  logic [IDX_W-1:0] mem [SLOTS];
  logic [IDX_W-1:0] rd_q_r;
  logic [IDX_W-1:0] dflt_q_r;
  logic             hit_q_r;
  logic [CNT_W-1:0] hw_r;
  logic [CNT_W-1:0] addr_p1;

  // Entries at or above the high-water mark have not been written since the
  // last fill or reset, so a read of one returns its own position as the free index.
  assign addr_p1 = CNT_W'(addr) + 1'b1;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wdata;
    end
    if (rd_en) begin
      rd_q_r   <= mem[addr];
      hit_q_r  <= (CNT_W'(addr) < hw_r);
      dflt_q_r <= IDX_W'(addr);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || fill) begin
      hw_r <= '0;
    end else if (wr_en && (addr_p1 > hw_r)) begin
      hw_r <= addr_p1;
    end
  end

  assign rd_data = hit_q_r ? rd_q_r : dflt_q_r;

  `ASSERT_CLKED(a_hw_in_range, hw_r <= CNT_W'(SLOTS), "high-water mark beyond stack depth")

endmodule

// File: src/spia_ctrl.sv
// Count and capacity registers and the alloc/free decision for each word.
// Depends on spia_pkg and assert_macros.svh.
`include "assert_macros.svh"

module spia_ctrl import spia_pkg::*; #(
  parameter int SLOTS = 64,
  localparam int AW    = $clog2(SLOTS),
  localparam int CNT_W = $clog2(SLOTS + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata,
  input  logic             accept,
  input  op_t              op,
  input  logic [IDX_W-1:0] free_index,
  output logic             rd_en,
  output logic             wr_en,
  output logic [AW-1:0]    addr,
  output logic [IDX_W-1:0] wdata,
  output res_info_t        info
);

  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic [CNT_W-1:0] cnt_dec;
  logic [CAP_W-1:0] cap_r;
  logic [CMP_W-1:0] cnt_ext;
  logic [CMP_W-1:0] cnt_nxt_ext;
  logic             full;
  logic             ignore;

  assign cnt_ext     = CMP_W'(cnt_r);
  assign cnt_nxt_ext = CMP_W'(cnt_nxt);
  assign cnt_dec     = cnt_r - 1'b1;
  // A capacity above the stack depth is limited by the depth check.
  assign full   = (cnt_ext >= CMP_W'(cap_r)) || (cnt_r >= CNT_W'(SLOTS));
  assign ignore = (free_index == '0) || (cnt_r <= CNT_W'(1));

  always_comb begin
    cnt_nxt       = cnt_r;
    rd_en         = 1'b0;
    wr_en         = 1'b0;
    addr          = cnt_r[AW-1:0];
    wdata         = free_index;
    info.alloc_ok = 1'b0;
    info.status   = ST_DONE;
    if (accept) begin
      unique case (op)
        OP_ALLOC: begin
          if (full) begin
            info.status = ST_FULL;
          end else begin
            rd_en         = 1'b1;
            info.alloc_ok = 1'b1;
            cnt_nxt       = cnt_r + 1'b1;
          end
        end
        OP_FREE: begin
          if (ignore) begin
            info.status = ST_IGNORED;
          end else begin
            wr_en   = 1'b1;
            addr    = cnt_dec[AW-1:0];
            cnt_nxt = cnt_dec;
          end
        end
        default: begin
          info.status = ST_DONE;
        end
      endcase
    end
    info.used_count = cnt_nxt_ext[CNT_OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= CNT_W'(1);
      cap_r <= CAP_RESET;
    end else if (cfg_we) begin
      cnt_r <= CNT_W'(1);
      cap_r <= cfg_wdata;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  `ASSERT_CLKED(a_cnt_range, (cnt_r >= CNT_W'(1)) && (cnt_r <= CNT_W'(SLOTS)), "used count out of range")
  `ASSERT_CLKED(a_rw_excl, !(rd_en && wr_en), "stack read and write in one cycle")

endmodule

// File: src/slot_pool_index_allocator_unit.sv
// Slot pool index allocator: an accepted word passes the first stage, then the output register.
// Throughput one word per cycle while the result side takes words; the stack is one
// single-port memory, read for an alloc and written for a free in the accepting cycle.
// Synchronous active-low reset: capacity 64, used count 1, stack entry i reads i.
// A capacity write reinitialises the pool at once; unwritten entries are tracked by
// a high-water mark, so neither reset nor a capacity write needs a clearing pass.
`include "assert_macros.svh"

module slot_pool_index_allocator_unit import spia_pkg::*; #(
  parameter int SLOTS = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  spia_req_if.sink         in_ch,
  spia_res_if.source       out_ch,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(SLOTS);

  logic             accept;
  logic             s1_adv;
  logic             s1_v_r;
  res_info_t        s1_info_r;
  res_info_t        info;
  logic             out_v_r;
  logic [IDX_W-1:0] out_slot_r;
  status_t          out_status_r;
  logic [CNT_OUT_W-1:0] out_cnt_r;
  logic             rd_en;
  logic             wr_en;
  logic [AW-1:0]    addr;
  logic [IDX_W-1:0] wdata;
  logic [IDX_W-1:0] rd_data;

  // The first stage waits for the memory read; the output register parts it
  // from the consumer so a new word can enter while a result waits.
  assign s1_adv      = s1_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !s1_v_r || s1_adv;
  assign accept      = in_ch.valid && in_ch.ready;

  spia_ctrl #(.SLOTS(SLOTS)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .accept     (accept),
    .op         (in_ch.op),
    .free_index (in_ch.free_index),
    .rd_en      (rd_en),
    .wr_en      (wr_en),
    .addr       (addr),
    .wdata      (wdata),
    .info       (info)
  );

  spia_stack #(.SLOTS(SLOTS)) u_stack (
    .clk     (clk),
    .rst_n   (rst_n),
    .fill    (cfg_we),
    .rd_en   (rd_en),
    .wr_en   (wr_en),
    .addr    (addr),
    .wdata   (wdata),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (accept) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_adv) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_info_r <= info;
    end
    if (s1_adv) begin
      out_slot_r   <= s1_info_r.alloc_ok ? rd_data : '0;
      out_status_r <= s1_info_r.status;
      out_cnt_r    <= s1_info_r.used_count;
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.slot_index = out_slot_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.used_count = out_cnt_r;

  `ASSERT_NEXT(a_s1_hold, s1_v_r && !s1_adv, s1_v_r && $stable(s1_info_r), "pending word lost")
  `ASSERT_CLKED(a_fail_zero, !out_v_r || (out_status_r == ST_DONE) || (out_slot_r == '0), "failed word carries an index")

endmodule
